@@ rtl/bsu_pkg.sv @@
package bsu_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int GRID_ROWS   = 32;
   localparam int GRID_COLS   = 128;

   localparam int SADDR_W    = $clog2(STACK_DEPTH);
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
   localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;
   localparam int GADDR_W    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
   localparam int GX_W       = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int GY_W       = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

   localparam logic [31:0] DIV_ZERO_VAL = 32'd42;
   localparam logic [31:0] MOD_ZERO_VAL = 32'h0badc0de;
   localparam logic [31:0] CHAR_MOD     = 32'd255;

   localparam logic CSR_GRID_ROWS = 1'b0;
   localparam logic CSR_GRID_COLS = 1'b1;

   typedef enum logic [3:0] {
      OP_PUSH       = 4'd0,
      OP_ADD        = 4'd1,
      OP_SUB        = 4'd2,
      OP_MUL        = 4'd3,
      OP_DIV        = 4'd4,
      OP_MOD        = 4'd5,
      OP_NOT        = 4'd6,
      OP_GT         = 4'd7,
      OP_DUP        = 4'd8,
      OP_SWAP       = 4'd9,
      OP_DROP       = 4'd10,
      OP_PRINT_INT  = 4'd11,
      OP_PRINT_CHAR = 4'd12,
      OP_GET        = 4'd13,
      OP_PUT        = 4'd14
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_INT  = 2'd1,
      KIND_CHAR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIV,
      ST_FIX,
      ST_GRID,
      ST_PUSH0,
      ST_PUSH1,
      ST_DONE
   } state_type;

   function automatic logic [1:0] pop_count(input op_type op);
      logic [1:0] n;
      n = 2'd0;
      unique case (op)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_SWAP, OP_GET: n = 2'd2;
         OP_NOT, OP_DUP, OP_DROP, OP_PRINT_INT, OP_PRINT_CHAR:           n = 2'd1;
         OP_PUT:                                                         n = 2'd3;
         default:                                                        n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [31:0] magnitude(input logic [31:0] v);
      return v[31] ? 32'd0 - v : v;
   endfunction

   // 256 = 1 mod 255, so byte sums keep the residue; a fold and a subtract get it below 255.
   function automatic logic [7:0] char_residue(input logic [31:0] m);
      logic [9:0] s1;
      logic [8:0] s2;
      s1 = {2'd0, m[7:0]} + {2'd0, m[15:8]} + {2'd0, m[23:16]} + {2'd0, m[31:24]};
      s2 = {1'b0, s1[7:0]} + {7'd0, s1[9:8]};
      if (s2 >= CHAR_MOD[8:0]) begin
         s2 = s2 - CHAR_MOD[8:0];
      end
      return s2[7:0];
   endfunction

endpackage

@@ rtl/befunge_stack_unit.sv @@
// An accepted word is handled in steps: the operands are read from the stack, the result is
// computed, up to two values are written back and the output register is loaded.
// Division and modulo by a nonzero divisor also pass through the bit-serial divider.
// One word is worked on at a time; the next is accepted in the cycle after the result loads.
// Reset is synchronous; afterwards all 4096 cells of the grid memory are cleared, one
// cell per cycle, and no word is accepted until that pass ends.
module befunge_stack_unit
   import bsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // push_value
   input  logic [3:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_value, stack_depth, overflow, zero fill
   output logic [1:0]  rsp_tuser,  // out_kind
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [7:0]  grid_mem [GRID_CELLS];

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [31:0]        pv_ff, pv_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [1:0]         k_ff, k_in;
   logic [31:0]        a_ff, a_in, b_ff, b_in, z_ff, z_in;
   logic [31:0]        v0_ff, v0_in, v1_ff, v1_in;
   logic [1:0]         npush_ff, npush_in;
   logic               ovf_ff, ovf_in;
   kind_type           kind_ff, kind_in;
   logic [31:0]        oval_ff, oval_in;
   logic [GADDR_W-1:0] clr_ff, clr_in;
   logic [5:0]         rows_ff;
   logic [7:0]         cols_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic [31:0]        rsp_val_ff, rsp_val_in;
   logic [CNT_W-1:0]   rsp_depth_ff, rsp_depth_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [31:0]        stk_rdata_ff;
   logic [SADDR_W-1:0] stk_raddr;
   logic               stk_we;
   logic [SADDR_W-1:0] stk_waddr;
   logic [31:0]        stk_wdata;

   logic [7:0]         grid_rdata_ff;
   logic               grid_we;
   logic [GADDR_W-1:0] grid_waddr;
   logic [7:0]         grid_wdata;
   logic [GADDR_W-1:0] grid_addr;
   logic               in_bounds;

   logic               div_start, div_done;
   logic [31:0]        div_dividend, div_divisor, div_quo, div_rem;
   logic [31:0]        rem_signed;
   logic [1:0]         npop;
   logic [CNT_W-1:0]   npop_ext;

   bsu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign npop     = pop_count(op_ff);
   assign npop_ext = CNT_W'(npop);

   assign grid_addr = GADDR_W'(GADDR_W'(a_ff[GX_W-1:0]) * GADDR_W'(GRID_COLS))
                      + GADDR_W'(b_ff[GY_W-1:0]);
   assign in_bounds = !a_ff[31] && !b_ff[31]
                      && (a_ff < {26'd0, rows_ff}) && (a_ff < 32'(GRID_ROWS))
                      && (b_ff < {24'd0, cols_ff}) && (b_ff < 32'(GRID_COLS));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pv_in        = pv_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      z_in         = z_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      npush_in     = npush_ff;
      ovf_in       = ovf_ff;
      kind_in      = kind_ff;
      oval_in      = oval_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      req_tready   = 1'b0;
      stk_raddr    = SADDR_W'(cnt_ff - CNT_W'(k_ff) - CNT_W'(1));
      stk_we       = 1'b0;
      stk_waddr    = SADDR_W'(cnt_ff);
      stk_wdata    = v0_ff;
      grid_we      = 1'b0;
      grid_waddr   = grid_addr;
      grid_wdata   = 8'd0;
      div_start    = 1'b0;
      div_dividend = magnitude(b_ff);
      div_divisor  = magnitude(a_ff);
      rem_signed   = 32'd0;

      unique case (state_ff)
         ST_CLEAR: begin
            grid_we    = 1'b1;
            grid_waddr = clr_ff;
            clr_in     = clr_ff + GADDR_W'(1);
            if (clr_ff == GADDR_W'(GRID_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = op_type'(req_tuser);
               pv_in    = req_tdata;
               k_in     = 2'd0;
               ovf_in   = 1'b0;
               kind_in  = KIND_NONE;
               oval_in  = 32'd0;
               npush_in = 2'd0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (k_ff != 2'd0) begin
               unique case (k_ff)
                  2'd1:    a_in = (cnt_ff >= CNT_W'(1)) ? stk_rdata_ff : 32'd0;
                  2'd2:    b_in = (cnt_ff >= CNT_W'(2)) ? stk_rdata_ff : 32'd0;
                  default: z_in = (cnt_ff >= CNT_W'(3)) ? stk_rdata_ff : 32'd0;
               endcase
            end
            k_in = k_ff + 2'd1;
            if (k_ff == npop) begin
               cnt_in   = (cnt_ff > npop_ext) ? cnt_ff - npop_ext : CNT_W'(0);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            npush_in = 2'd1;
            state_in = ST_PUSH0;
            unique case (op_ff)
               OP_PUSH: v0_in = pv_ff;
               OP_ADD:  v0_in = b_ff + a_ff;
               OP_SUB:  v0_in = b_ff - a_ff;
               OP_MUL:  v0_in = b_ff * a_ff;
               OP_DIV, OP_MOD: begin
                  if (a_ff == 32'd0) begin
                     v0_in = (op_ff == OP_DIV) ? DIV_ZERO_VAL : MOD_ZERO_VAL;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               OP_NOT: v0_in = {31'd0, a_ff == 32'd0};
               OP_GT:  v0_in = {31'd0, $signed(b_ff) > $signed(a_ff)};
               OP_DUP: begin
                  v0_in    = a_ff;
                  v1_in    = a_ff;
                  npush_in = 2'd2;
               end
               OP_SWAP: begin
                  v0_in    = a_ff;
                  v1_in    = b_ff;
                  npush_in = 2'd2;
               end
               OP_DROP: npush_in = 2'd0;
               OP_PRINT_INT: begin
                  npush_in = 2'd0;
                  kind_in  = KIND_INT;
                  oval_in  = a_ff;
               end
               OP_PRINT_CHAR: begin
                  v0_in    = {24'd0, char_residue(magnitude(a_ff))};
                  npush_in = 2'd0;
                  state_in = ST_FIX;
               end
               OP_GET: begin
                  if (in_bounds) begin
                     state_in = ST_GRID;
                  end else begin
                     v0_in = 32'd0;
                  end
               end
               OP_PUT: begin
                  npush_in = 2'd0;
                  if (in_bounds) begin
                     v0_in    = {24'd0, char_residue(magnitude(z_ff))};
                     state_in = ST_FIX;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  npush_in = 2'd0;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            state_in = ST_PUSH0;
            unique case (op_ff)
               OP_DIV: v0_in = (a_ff[31] != b_ff[31]) ? 32'd0 - div_quo : div_quo;
               OP_MOD: v0_in = b_ff[31] ? 32'd0 - div_rem : div_rem;
               OP_PRINT_CHAR: begin
                  rem_signed = a_ff[31] ? 32'd0 - v0_ff : v0_ff;
                  kind_in    = KIND_CHAR;
                  oval_in    = {24'd0, rem_signed[7:0]};
                  state_in   = ST_DONE;
               end
               default: begin
                  rem_signed = z_ff[31] ? 32'd0 - v0_ff : v0_ff;
                  grid_we    = 1'b1;
                  grid_wdata = rem_signed[7:0];
                  state_in   = ST_DONE;
               end
            endcase
         end
         ST_GRID: begin
            v0_in    = {24'd0, grid_rdata_ff};
            state_in = ST_PUSH0;
         end
         ST_PUSH0: begin
            state_in = ST_DONE;
            if (npush_ff != 2'd0) begin
               if (cnt_ff < CNT_W'(STACK_DEPTH)) begin
                  stk_we = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (npush_ff == 2'd2) begin
                  state_in = ST_PUSH1;
               end
            end
         end
         ST_PUSH1: begin
            stk_wdata = v1_ff;
            state_in  = ST_DONE;
            if (cnt_ff < CNT_W'(STACK_DEPTH)) begin
               stk_we = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_val_in   = oval_ff;
               rsp_depth_in = cnt_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= 6'd25;
         cols_ff      <= 8'd80;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GRID_ROWS: rows_ff <= csr_wdata[5:0];
               CSR_GRID_COLS: cols_ff <= csr_wdata;
            endcase
         end
      end
      op_ff        <= op_in;
      pv_ff        <= pv_in;
      k_ff         <= k_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      z_ff         <= z_in;
      v0_ff        <= v0_in;
      v1_ff        <= v1_in;
      npush_ff     <= npush_in;
      ovf_ff       <= ovf_in;
      kind_ff      <= kind_in;
      oval_ff      <= oval_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stack_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= grid_wdata;
      end
      grid_rdata_ff <= grid_mem[grid_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'd0, rsp_ovf_ff, 9'(rsp_depth_ff), rsp_val_ff};

endmodule

@@ rtl/bsu_div.sv @@
module bsu_div
   import bsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic        busy_ff, busy_in;
   logic [4:0]  step_ff, step_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         step_in = 5'd0;
         rem_in  = 33'd0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[31:0];

endmodule

@@ rtl/bsu_checker.sv @@
module bsu_checker
   import bsu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic [3:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_we,
   input logic        csr_index,
   input logic [7:0]  csr_wdata
);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word withdrawn before it was taken");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41] |-> rsp_tdata[40:32] == 9'(STACK_DEPTH))
      else $error("overflow reported while the stack is not full");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[40:32] <= 9'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_NONE |-> rsp_tdata[31:0] == 32'd0)
      else $error("value present on a word that prints nothing");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted before the first was finished");

endmodule

bind befunge_stack_unit bsu_checker u_bsu_checker (.*);
